FILE: design/adm_pkg.sv
package adm_pkg;

  localparam int CLASSES_DEF    = 256;
  localparam int SCORE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } adm_op_t;

  // one pending read between the memory access and the output register
  typedef struct packed {
    logic valid;
    logic in_range;
    logic diag;
    logic best_valid;
  } adm_rd_ctl_t;

endpackage

FILE: design/adm_adj_mem.sv
module adm_adj_mem #(
  parameter int CW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [2*CW-1:0] wr_addr,
  input  logic            wr_data,
  input  logic            rd_en,
  input  logic [2*CW-1:0] rd_addr,
  output logic            rd_data,
  output logic            busy
);

  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/adm_score_buf.sv
module adm_score_buf #(
  parameter int CLASSES    = 256,
  parameter int SCORE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(CLASSES)-1:0]   wr_addr,
  input  logic signed [SCORE_BITS-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(CLASSES)-1:0]   rd_addr,
  output logic signed [SCORE_BITS-1:0] rd_data
);

  logic signed [SCORE_BITS-1:0] mem [CLASSES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/argmax_adjacency_mask_filter_unit.sv
// channel | handshake            | word
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_stall  | operation anchor_row class_index allowed_bit
//         |                      | score_value
// out     | out_valid / out_stall| filtered_score anchor_class anchor_found
//
// One word is accepted per cycle while in_stall is low; a read's result passes
// through the score buffer and adjacency memory read, then the output register.
// Reset is synchronous; after it the adjacency memory is swept clear, one bit
// per cycle, over all 2**(2*clog2(CLASSES)) bits (65536 at 256 classes) with
// in_stall high. A read waiting behind a stalled output holds in_stall high.
module argmax_adjacency_mask_filter_unit #(
  parameter int CLASSES    = adm_pkg::CLASSES_DEF,
  parameter int SCORE_BITS = adm_pkg::SCORE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic [7:0]                   anchor_row,
  input  logic [7:0]                   class_index,
  input  logic                         allowed_bit,
  input  logic signed [SCORE_BITS-1:0] score_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SCORE_BITS-1:0] filtered_score,
  output logic [7:0]                   anchor_class,
  output logic                         anchor_found
);

  import adm_pkg::*;

  localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int IW = (CW > 8) ? CW : 8;
  localparam logic signed [SCORE_BITS-1:0] MINUS_ONE =
    -(SCORE_BITS'(1) << (SCORE_BITS - 4));

  adm_op_t op;
  logic    accept, do_write, do_load, do_read;
  logic    row_ok, idx_ok;
  logic [IW-1:0] row_w, idx_w;
  logic [CW-1:0] row_a, idx_a;
  logic    clr_busy;
  logic    adj_bit;
  logic signed [SCORE_BITS-1:0] score_rd;

  logic signed [SCORE_BITS-1:0] best_score, base_score;
  logic [CW-1:0] best_class, base_class;
  logic          best_valid, base_valid;
  logic [CW:0]   loaded_count, base_count;
  logic [IW:0]   idx_plus;

  adm_rd_ctl_t pend;
  logic [CW-1:0] pend_class;
  logic          pend_move;

  assign op    = adm_op_t'(operation);
  assign row_w = IW'(anchor_row);
  assign idx_w = IW'(class_index);
  assign row_a = row_w[CW-1:0];
  assign idx_a = idx_w[CW-1:0];
  assign row_ok = 32'(anchor_row) < CLASSES;
  assign idx_ok = 32'(class_index) < CLASSES;

  assign pend_move = !out_valid || !out_stall;
  assign in_stall  = clr_busy || (pend.valid && !pend_move);
  assign accept    = in_valid && !in_stall;
  assign do_write  = accept && (op == OP_WRITE) && row_ok && idx_ok;
  assign do_load   = accept && (op == OP_LOAD) && idx_ok;
  assign do_read   = accept && (op == OP_READ);

  adm_adj_mem #(.CW(CW)) u_adj (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (do_write),
    .wr_addr ({row_a, idx_a}),
    .wr_data (allowed_bit),
    .rd_en   (do_read),
    .rd_addr ({best_class, idx_a}),
    .rd_data (adj_bit),
    .busy    (clr_busy)
  );

  adm_score_buf #(.CLASSES(CLASSES), .SCORE_BITS(SCORE_BITS)) u_score (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_addr (idx_a),
    .wr_data (score_value),
    .rd_en   (do_read),
    .rd_addr (idx_a),
    .rd_data (score_rd)
  );

  // index 0 restarts the vector
  always_comb begin
    if (class_index == 8'd0) begin
      base_score = MINUS_ONE;
      base_class = '0;
      base_valid = 1'b0;
      base_count = '0;
    end else begin
      base_score = best_score;
      base_class = best_class;
      base_valid = best_valid;
      base_count = loaded_count;
    end
    idx_plus = {1'b0, idx_w} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score   <= MINUS_ONE;
      best_class   <= '0;
      best_valid   <= 1'b0;
      loaded_count <= '0;
    end else if (do_load) begin
      if (idx_plus > (IW + 1)'(base_count)) begin
        loaded_count <= idx_plus[CW:0];
      end else begin
        loaded_count <= base_count;
      end
      if (score_value > base_score) begin
        best_score <= score_value;
        best_class <= idx_a;
        best_valid <= 1'b1;
      end else begin
        best_score <= base_score;
        best_class <= base_class;
        best_valid <= base_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
    end else if (do_read) begin
      pend.valid <= 1'b1;
    end else if (pend_move) begin
      pend.valid <= 1'b0;
    end
    if (do_read) begin
      pend.in_range   <= idx_ok && ((IW + 1)'(class_index) < (IW + 1)'(loaded_count));
      pend.diag       <= best_class == idx_a;
      pend.best_valid <= best_valid;
      pend_class      <= best_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= pend.valid;
    end
    if (pend_move && pend.valid) begin
      if (pend.in_range && !(pend.best_valid && !pend.diag && !adj_bit)) begin
        filtered_score <= score_rd;
      end else begin
        filtered_score <= '0;
      end
      anchor_class <= 8'(pend_class);
      anchor_found <= pend.best_valid;
    end
  end

  a_read_pends: assert property (@(posedge clk) disable iff (rst)
    do_read |=> pend.valid)
    else $error("accepted read left no pending entry");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(loaded_count) <= CLASSES)
    else $error("loaded count beyond class count");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !pend.valid && !out_valid)
    else $error("result in flight during clear sweep");

  a_load_counts: assert property (@(posedge clk) disable iff (rst)
    do_load |=> loaded_count != '0)
    else $error("load did not raise loaded count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_score))
    else $error("stalled result changed");

endmodule

FILE: verif/argmax_adjacency_mask_filter_unit_test.sv
module argmax_adjacency_mask_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import adm_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1300;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [15:0] MINUS_ONE = -16'sd4096;

  typedef struct packed {
    logic signed [15:0] score;
    logic [7:0]         anchor;
    logic               found;
  } filt_word_t;

  class masked_argmax_sb;
    bit                 link_map [65536];
    logic signed [15:0] held_score [256];
    bit                 held_seen [256];
    logic signed [15:0] top_score;
    logic [7:0]         top_class;
    bit                 top_found;
    int                 fill_count;
    logic [7:0]         last_load;
    filt_word_t         expected_reads [$];
    int                 errors, reads, masked, no_anchor, loads, writes;

    function new();
      top_score = MINUS_ONE;
      top_class = '0;
      top_found = 1'b0;
      fill_count = 0;
      last_load = '0;
    endfunction

    function void note_word(adm_op_t op, logic [7:0] row, logic [7:0] idx, logic allow,
                            logic signed [15:0] val);
      filt_word_t w;
      case (op)
        OP_WRITE: begin
          link_map[{row, idx}] = allow;
          writes++;
        end
        OP_LOAD: begin
          if (idx == 8'd0) begin
            top_score = MINUS_ONE;
            top_class = '0;
            top_found = 1'b0;
            fill_count = 0;
          end
          held_score[idx] = val;
          held_seen[idx] = 1'b1;
          last_load = idx;
          if (int'(idx) + 1 > fill_count) fill_count = int'(idx) + 1;
          if (val > top_score) begin
            top_score = val;
            top_class = idx;
            top_found = 1'b1;
          end
          loads++;
        end
        OP_READ: begin
          w.score = '0;
          if (int'(idx) < fill_count) begin
            w.score = held_score[idx];
            // the anchor itself always passes
            if (top_found && top_class != idx && !link_map[{top_class, idx}]) begin
              w.score = '0;
              masked++;
            end
          end
          w.anchor = top_class;
          w.found = top_found;
          if (!top_found) no_anchor++;
          reads++;
          expected_reads = {expected_reads, w};
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic signed [15:0] fs, logic [7:0] ac, logic af);
      filt_word_t w;
      if (expected_reads.size() == 0) begin
        $error("unexpected word: filtered_score %0d anchor_class %0d anchor_found %0b",
               fs, ac, af);
        errors++;
        return;
      end
      w = expected_reads.pop_front();
      if (fs !== w.score) begin
        $error("filtered_score expected %0d actual %0d", w.score, fs);
        errors++;
      end
      if (ac !== w.anchor) begin
        $error("anchor_class expected %0d actual %0d", w.anchor, ac);
        errors++;
      end
      if (af !== w.found) begin
        $error("anchor_found expected %0b actual %0b", w.found, af);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          operation;
  logic [7:0]          anchor_row;
  logic [7:0]          class_index;
  logic                allowed_bit;
  logic signed [15:0]  score_value;
  logic                out_valid;
  logic                out_stall;
  logic signed [15:0]  filtered_score;
  logic [7:0]          anchor_class;
  logic                anchor_found;

  masked_argmax_sb sb;
  int words;
  int results;
  bit no_gaps;
  bit held_once;

  argmax_adjacency_mask_filter_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .anchor_row     (anchor_row),
    .class_index    (class_index),
    .allowed_bit    (allowed_bit),
    .score_value    (score_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_score (filtered_score),
    .anchor_class   (anchor_class),
    .anchor_found   (anchor_found)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic put(adm_op_t op, logic [7:0] row, logic [7:0] idx, logic allow,
                     logic signed [15:0] val);
    int r, len;
    in_valid <= 1'b1;
    operation <= op;
    anchor_row <= row;
    class_index <= idx;
    allowed_bit <= allow;
    score_value <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(op, row, idx, allow, val);
    if (op != OP_NONE) words++;
    r = $urandom_range(99);
    if (no_gaps || r < 50) len = 0;
    else if (r < 92) len = $urandom_range(1, 3);
    else len = $urandom_range(8, 40);
    if (len > 0) begin
      in_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // never read a buffer slot below the fill count that was never loaded
  task automatic read_at(logic [7:0] idx);
    if (int'(idx) < sb.fill_count && !sb.held_seen[idx]) idx = sb.last_load;
    put(OP_READ, 8'($urandom), idx, 1'($urandom), 16'($urandom));
  endtask

  task automatic write_link(int span);
    int lim, r;
    logic [7:0] row;
    lim = (span + 3 > 255) ? 255 : span + 3;
    r = $urandom_range(9);
    if (r < 6) row = sb.top_class;
    else if (r < 9) row = 8'($urandom_range(0, lim));
    else row = 8'($urandom);
    put(OP_WRITE, row, 8'($urandom_range(0, lim)), 1'($urandom_range(2) != 0),
        16'($urandom));
  endtask

  function automatic logic signed [15:0] pick_score(int style);
    logic signed [15:0] corners [8];
    logic signed [15:0] ties [4];
    corners = '{-16'sd32768, 16'sd32767, -16'sd4096, -16'sd4097, -16'sd4095,
                16'sd0, -16'sd1, 16'sd1};
    ties = '{16'sd100, 16'sd2000, -16'sd4096, 16'sd2000};
    case (style)
      0: return 16'($urandom);
      1: return corners[$urandom_range(7)];
      2: return 16'(int'($urandom_range(0, 28672)) - 32768);
      default: return ties[$urandom_range(3)];
    endcase
  endfunction

  initial begin
    int start, pick, n, k, i, style;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_NONE;
    anchor_row = '0;
    class_index = '0;
    allowed_bit = 1'b0;
    score_value = '0;
    words = 0;
    results = 0;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    read_at(8'd0);
    put(OP_WRITE, 8'd0, 8'd0, 1'b0, 16'sd0);
    put(OP_WRITE, 8'd255, 8'd255, 1'b1, -16'sd1);
    put(OP_WRITE, 8'd3, 8'd7, 1'b1, 16'sd0);
    put(OP_WRITE, 8'd3, 8'd200, 1'b1, 16'sd0);
    put(OP_WRITE, 8'd3, 8'd200, 1'b0, 16'sd0);
    put(OP_LOAD, 8'd0, 8'd0, 1'b0, MINUS_ONE);
    put(OP_LOAD, 8'd0, 8'd1, 1'b0, -16'sd32768);
    read_at(8'd0);
    read_at(8'd1);
    put(OP_LOAD, 8'd0, 8'd2, 1'b0, -16'sd4095);
    read_at(8'd1);
    put(OP_LOAD, 8'd0, 8'd3, 1'b0, 16'sd32767);
    put(OP_LOAD, 8'd0, 8'd4, 1'b0, 16'sd32767);
    put(OP_WRITE, 8'd3, 8'd5, 1'b1, 16'sd0);
    put(OP_LOAD, 8'd0, 8'd5, 1'b0, 16'sd1);
    read_at(8'd3);
    read_at(8'd4);
    read_at(8'd5);
    read_at(8'd7);
    put(OP_NONE, 8'hff, 8'hff, 1'b1, -16'sd1);
    put(OP_LOAD, 8'hff, 8'd255, 1'b1, 16'sd32767);
    read_at(8'd255);
    put(OP_WRITE, 8'd3, 8'd255, 1'b1, 16'sd0);
    read_at(8'd255);

    start = words;
    while (words - start < RANDOM_WORDS) begin
      pick = $urandom_range(99);
      no_gaps = ($urandom_range(5) == 0);
      if (pick < 80) begin
        style = $urandom_range(3);
        n = ($urandom_range(39) == 0) ? 256 : $urandom_range(1, 24);
        k = $urandom_range(5);
        repeat (k) write_link(n);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(29) == 0) continue;
          put(OP_LOAD, 8'($urandom), 8'(i), 1'($urandom), pick_score(style));
          if ($urandom_range(15) == 0) write_link(n);
        end
        k = $urandom_range(2, 12);
        repeat (k) begin
          if ($urandom_range(4) == 0) write_link(n);
          read_at(8'($urandom_range(0, (n + 3 > 255) ? 255 : n + 3)));
        end
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          pick = $urandom_range(3);
          if (adm_op_t'(2'(pick)) == OP_READ) read_at(8'($urandom));
          else put(adm_op_t'(2'(pick)), 8'($urandom), 8'($urandom), 1'($urandom),
                   16'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("ran %0d words: %0d adjacency writes, %0d score loads, %0d reads",
             words, sb.writes, sb.loads, sb.reads);
    $display("%0d reads masked to zero, %0d with no anchor, long output hold done: %0b",
             sb.masked, sb.no_anchor, held_once);
    if (sb.errors == 0 && sb.expected_reads.size() == 0)
      $display("argmax_adjacency_mask_filter_unit_test OK");
    else
      $display("argmax_adjacency_mask_filter_unit_test NOT OK");
    $finish;
  end

  initial begin
    int r, len;
    out_stall = 1'b0;
    held_once = 1'b0;
    forever begin
      if (!held_once && results >= 150) begin
        // hold the output long enough for the input side to back up
        held_once = 1'b1;
        out_stall <= 1'b1;
        len = HOLD_CYCLES;
      end else begin
        r = $urandom_range(99);
        if (r < 45) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 20);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(10, 50);
        end
      end
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_word(filtered_score, anchor_class, anchor_found);
      results++;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("argmax_adjacency_mask_filter_unit_test NOT OK");
    $finish;
  end

endmodule

FILE: files.f
design/adm_pkg.sv
design/adm_adj_mem.sv
design/adm_score_buf.sv
design/argmax_adjacency_mask_filter_unit.sv
verif/argmax_adjacency_mask_filter_unit_test.sv
